### hw/rtl/lgmc_pkg.sv
// Package for the label group min-cost table.
// Holds the action and status codes, the sequencer states and the port field widths.
// It depends on nothing else.
`default_nettype none

package lgmc_pkg;

  localparam int ACTION_W = 3;
  localparam int LABEL_W = 10;
  localparam int COST_PORT_W = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NEW_GROUP = 3'd0,
    ACT_ADD_LABEL = 3'd1,
    ACT_MOVE_GROUP = 3'd2,
    ACT_REMAP = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_RECOMPUTE = 3'd5,
    ACT_QUERY = 3'd6
  } act_t;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LAB,
    S_UPD,
    S_RES,
    S_WALK
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/label_group_min_cost_table_top.sv
// Label group min-cost table: a label memory {valid, group, cost} and a group cost memory.
// Single-entry actions go from the accept through S_LAB, and some on through S_UPD or S_RES,
// to S_IDLE; the result strobe comes in the cycle after the last state. Move (across groups)
// and recompute walk the label memory, one entry per cycle through its read port.
// After reset, a clearing pass empties the label memory and busy is high.
// Results are strobed on out_valid for one cycle, and the receiver cannot stall.
`default_nettype none

module label_group_min_cost_table_top
  import lgmc_pkg::*;
#(
  parameter int MAX_LABELS = 1024,
  parameter int COST_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [ACTION_W-1:0]    in_action,
  input  wire logic [LABEL_W-1:0]     in_label,
  input  wire logic [LABEL_W-1:0]     in_new_label,
  input  wire logic [LABEL_W-1:0]     in_dest_group,
  input  wire logic [LABEL_W-1:0]     in_source_group,
  input  wire logic [COST_PORT_W-1:0] in_label_cost,
  input  wire logic                   in_separate_mode,
  output logic                        out_valid,
  output logic [LABEL_W-1:0]          out_result_group,
  output logic [COST_PORT_W-1:0]      out_group_cost,
  output logic [STATUS_W-1:0]         out_status
);

  localparam int LW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int CW = COST_BITS;
  localparam int XW = LW + LABEL_W + 1;
  localparam logic [CW-1:0] INF = '1;
  localparam logic [LW-1:0] LAST = LW'(MAX_LABELS - 1);
  localparam logic [LW:0] FULL_COUNT = (LW + 1)'(MAX_LABELS);
  localparam logic [XW-1:0] LABEL_LIMIT = XW'(MAX_LABELS);

  typedef struct packed {
    logic          valid;
    logic [LW-1:0] grp;
    logic [CW-1:0] cost;
  } lbl_word_t;

  lbl_word_t lmem [MAX_LABELS];
  logic [CW-1:0] gmem [MAX_LABELS];

  state_t state_r, state_nxt;
  act_t act_r;
  logic [LABEL_W-1:0] lab_r, nlab_r, grp_r, src_r;
  logic [CW-1:0] cost_r;
  logic sep_r;
  logic [LW:0] giu_r, giu_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] g_r, g_nxt;
  logic [LW-1:0] tgt_r, tgt_nxt;
  logic [CW-1:0] acc_r, acc_nxt;
  logic fresh_r, fresh_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0] out_grp_r, out_grp_nxt;
  logic [COST_PORT_W-1:0] out_cost_r, out_cost_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic l_we, l_re;
  logic [LW-1:0] l_wa, l_ra;
  lbl_word_t l_wd, lrd_r;
  logic g_we, g_re;
  logic [LW-1:0] g_wa, g_ra;
  logic [CW-1:0] g_wd, grd_r;

  logic accept;
  logic lab_in, nlab_in, lab_ok, grp_ok, src_ok, full;
  logic [CW-1:0] upd_base, upd_min, walk_base, walk_min;
  logic walk_match;

  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign lab_in = XW'(lab_r) < LABEL_LIMIT;
  assign nlab_in = XW'(nlab_r) < LABEL_LIMIT;
  assign lab_ok = lab_in && lrd_r.valid;
  assign grp_ok = XW'(grp_r) < XW'(giu_r);
  assign src_ok = XW'(src_r) < XW'(giu_r);
  assign full = (giu_r == FULL_COUNT);

  assign upd_base = fresh_r ? INF : grd_r;
  assign upd_min = (cost_r < upd_base) ? cost_r : upd_base;

  assign walk_base = (idx_r == '0) ? ((act_r == ACT_MOVE_GROUP) ? grd_r : INF) : acc_r;
  assign walk_match = lrd_r.valid &&
                      (lrd_r.grp == ((act_r == ACT_MOVE_GROUP) ? LW'(src_r) : g_r));
  assign walk_min = (walk_match && (lrd_r.cost < walk_base)) ? lrd_r.cost : walk_base;

  always_comb begin
    state_nxt = state_r;
    giu_nxt = giu_r;
    idx_nxt = idx_r;
    g_nxt = g_r;
    tgt_nxt = tgt_r;
    acc_nxt = acc_r;
    fresh_nxt = fresh_r;
    out_valid_nxt = 1'b0;
    out_grp_nxt = out_grp_r;
    out_cost_nxt = out_cost_r;
    out_status_nxt = out_status_r;
    l_we = 1'b0;
    l_wa = '0;
    l_wd = '0;
    l_re = 1'b0;
    l_ra = '0;
    g_we = 1'b0;
    g_wa = '0;
    g_wd = '0;
    g_re = 1'b0;
    g_ra = '0;

    unique case (state_r)
      S_CLEAR: begin
        l_we = 1'b1;
        l_wa = idx_r;
        if (idx_r == LAST) begin
          idx_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          l_re = 1'b1;
          l_ra = LW'(in_label);
          state_nxt = S_LAB;
        end
      end
      S_LAB: begin
        out_valid_nxt = 1'b1;
        out_grp_nxt = '0;
        out_cost_nxt = COST_PORT_W'(INF);
        out_status_nxt = ST_ABSENT;
        state_nxt = S_IDLE;
        unique case (act_r)
          ACT_NEW_GROUP: begin
            if (full) begin
              out_status_nxt = ST_FULL;
            end else begin
              g_we = 1'b1;
              g_wa = LW'(giu_r);
              g_wd = INF;
              giu_nxt = giu_r + 1'b1;
              out_grp_nxt = LABEL_W'(giu_r);
              out_status_nxt = ST_OK;
            end
          end
          ACT_ADD_LABEL: begin
            if (grp_ok && lab_in) begin
              out_valid_nxt = 1'b0;
              g_re = 1'b1;
              g_ra = LW'(grp_r);
              g_nxt = LW'(grp_r);
              tgt_nxt = LW'(lab_r);
              fresh_nxt = 1'b0;
              state_nxt = S_UPD;
            end
          end
          ACT_MOVE_GROUP: begin
            if (grp_ok && src_ok) begin
              out_valid_nxt = 1'b0;
              g_re = 1'b1;
              g_ra = LW'(grp_r);
              g_nxt = LW'(grp_r);
              if (src_r == grp_r) begin
                state_nxt = S_RES;
              end else begin
                l_re = 1'b1;
                l_ra = '0;
                idx_nxt = '0;
                state_nxt = S_WALK;
              end
            end
          end
          ACT_REMAP: begin
            if (lab_ok && nlab_in) begin
              if (sep_r && full) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_valid_nxt = 1'b0;
                l_we = 1'b1;
                l_wa = LW'(lab_r);
                tgt_nxt = LW'(nlab_r);
                state_nxt = S_UPD;
                if (sep_r) begin
                  g_nxt = LW'(giu_r);
                  giu_nxt = giu_r + 1'b1;
                  fresh_nxt = 1'b1;
                end else begin
                  g_re = 1'b1;
                  g_ra = lrd_r.grp;
                  g_nxt = lrd_r.grp;
                  fresh_nxt = 1'b0;
                end
              end
            end
          end
          ACT_REMOVE: begin
            if (lab_ok) begin
              out_valid_nxt = 1'b0;
              l_we = 1'b1;
              l_wa = LW'(lab_r);
              g_re = 1'b1;
              g_ra = lrd_r.grp;
              g_nxt = lrd_r.grp;
              state_nxt = S_RES;
            end
          end
          ACT_RECOMPUTE: begin
            if (grp_ok) begin
              out_valid_nxt = 1'b0;
              g_nxt = LW'(grp_r);
              l_re = 1'b1;
              l_ra = '0;
              idx_nxt = '0;
              state_nxt = S_WALK;
            end
          end
          ACT_QUERY: begin
            if (lab_ok) begin
              out_valid_nxt = 1'b0;
              g_re = 1'b1;
              g_ra = lrd_r.grp;
              g_nxt = lrd_r.grp;
              state_nxt = S_RES;
            end
          end
          default: begin
            out_status_nxt = ST_ABSENT;
          end
        endcase
      end
      S_UPD: begin
        l_we = 1'b1;
        l_wa = tgt_r;
        l_wd = '{valid: 1'b1, grp: g_r, cost: cost_r};
        g_we = 1'b1;
        g_wa = g_r;
        g_wd = upd_min;
        out_valid_nxt = 1'b1;
        out_grp_nxt = LABEL_W'(g_r);
        out_cost_nxt = COST_PORT_W'(upd_min);
        out_status_nxt = ST_OK;
        state_nxt = S_IDLE;
      end
      S_RES: begin
        out_valid_nxt = 1'b1;
        out_grp_nxt = LABEL_W'(g_r);
        out_cost_nxt = COST_PORT_W'(grd_r);
        out_status_nxt = ST_OK;
        state_nxt = S_IDLE;
      end
      S_WALK: begin
        acc_nxt = walk_min;
        if (walk_match && (act_r == ACT_MOVE_GROUP)) begin
          l_we = 1'b1;
          l_wa = idx_r;
          l_wd = '{valid: 1'b1, grp: g_r, cost: lrd_r.cost};
        end
        if (idx_r == LAST) begin
          g_we = 1'b1;
          g_wa = g_r;
          g_wd = walk_min;
          idx_nxt = '0;
          out_valid_nxt = 1'b1;
          out_grp_nxt = LABEL_W'(g_r);
          out_cost_nxt = COST_PORT_W'(walk_min);
          out_status_nxt = ST_OK;
          state_nxt = S_IDLE;
        end else begin
          l_re = 1'b1;
          l_ra = idx_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      giu_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      giu_r <= giu_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= act_t'(in_action);
      lab_r <= in_label;
      nlab_r <= in_new_label;
      grp_r <= in_dest_group;
      src_r <= in_source_group;
      cost_r <= CW'(in_label_cost);
      sep_r <= in_separate_mode;
    end
    g_r <= g_nxt;
    tgt_r <= tgt_nxt;
    acc_r <= acc_nxt;
    fresh_r <= fresh_nxt;
    out_grp_r <= out_grp_nxt;
    out_cost_r <= out_cost_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[l_wa] <= l_wd;
    end
    if (l_re) begin
      lrd_r <= lmem[l_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_wa] <= g_wd;
    end
    if (g_re) begin
      grd_r <= gmem[g_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_group = out_grp_r;
  assign out_group_cost = out_cost_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

### tb/label_group_min_cost_table_top_test.sv
// Self-checking testbench for label_group_min_cost_table_top: directed and random
// group and label commands, with every result compared against an in-bench table model.
// It depends on lgmc_pkg and the label_group_min_cost_table_top RTL.
module label_group_min_cost_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lgmc_pkg::*;

  localparam int NLAB = 1024;
  localparam int END_HOLD = NLAB + 64;
  localparam logic [COST_PORT_W-1:0] COST_INF = '1;
  localparam logic [COST_PORT_W-1:0] COST_TOP = COST_INF - 1'b1;
  localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 3'd7;

  typedef struct {
    logic [ACTION_W-1:0]    action;
    logic [LABEL_W-1:0]     lab;
    logic [LABEL_W-1:0]     new_lab;
    logic [LABEL_W-1:0]     dest_group;
    logic [LABEL_W-1:0]     src_group;
    logic [COST_PORT_W-1:0] cost;
    logic                   sep;
  } lg_cmd_t;

  typedef struct {
    logic [LABEL_W-1:0]     grp;
    logic [COST_PORT_W-1:0] cost;
    logic [STATUS_W-1:0]    status;
  } lg_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ACTION_W-1:0] in_action = '0;
  logic [LABEL_W-1:0] in_label = '0;
  logic [LABEL_W-1:0] in_new_label = '0;
  logic [LABEL_W-1:0] in_dest_group = '0;
  logic [LABEL_W-1:0] in_source_group = '0;
  logic [COST_PORT_W-1:0] in_label_cost = '0;
  logic in_separate_mode = 1'b0;
  logic out_valid;
  logic [LABEL_W-1:0] out_result_group;
  logic [COST_PORT_W-1:0] out_group_cost;
  logic [STATUS_W-1:0] out_status;

  bit lbl_valid [NLAB];
  logic [LABEL_W-1:0] lbl_group [NLAB];
  logic [COST_PORT_W-1:0] lbl_cost [NLAB];
  logic [COST_PORT_W-1:0] grp_cost [NLAB];
  int unsigned grp_count = 0;

  lg_cmd_t pending_cmds [$];
  lg_result_t results_due [$];
  lg_cmd_t cmd_on_port;
  lg_result_t due_head;

  int idle_pct = 0;
  int unsigned n_beats = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_walks = 0;
  int unsigned n_full = 0;
  int unsigned n_absent = 0;

  always #10 clk = ~clk;

  label_group_min_cost_table_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_label         (in_label),
    .in_new_label     (in_new_label),
    .in_dest_group    (in_dest_group),
    .in_source_group  (in_source_group),
    .in_label_cost    (in_label_cost),
    .in_separate_mode (in_separate_mode),
    .out_valid        (out_valid),
    .out_result_group (out_result_group),
    .out_group_cost   (out_group_cost),
    .out_status       (out_status)
  );

  function automatic lg_result_t ok_result(input int unsigned g);
    lg_result_t r;
    r.grp = LABEL_W'(g);
    r.cost = grp_cost[g];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic void put_label(input int unsigned lab, input int unsigned g,
                                    input logic [COST_PORT_W-1:0] c);
    lbl_valid[lab] = 1'b1;
    lbl_group[lab] = LABEL_W'(g);
    lbl_cost[lab] = c;
    if (c < grp_cost[g]) begin
      grp_cost[g] = c;
    end
  endfunction

  function automatic void predict_group_result(input lg_cmd_t c);
    lg_result_t r;
    int unsigned g;
    int i;
    bit grp_open;
    bit src_open;
    bit lab_on;
    r.grp = '0;
    r.cost = COST_INF;
    r.status = ST_ABSENT;
    grp_open = 32'(c.dest_group) < grp_count;
    src_open = 32'(c.src_group) < grp_count;
    lab_on = lbl_valid[c.lab];
    case (c.action)
      ACT_NEW_GROUP: begin
        if (grp_count >= NLAB) begin
          r.status = ST_FULL;
        end else begin
          g = grp_count;
          grp_count++;
          grp_cost[g] = COST_INF;
          r = ok_result(g);
        end
      end
      ACT_ADD_LABEL: begin
        if (grp_open) begin
          put_label(32'(c.lab), 32'(c.dest_group), c.cost);
          r = ok_result(32'(c.dest_group));
        end
      end
      ACT_MOVE_GROUP: begin
        if (grp_open && src_open) begin
          if (c.src_group != c.dest_group) begin
            n_walks++;
            for (i = 0; i < NLAB; i++) begin
              if (lbl_valid[i] && lbl_group[i] == c.src_group) begin
                put_label(i, 32'(c.dest_group), lbl_cost[i]);
              end
            end
          end
          r = ok_result(32'(c.dest_group));
        end
      end
      ACT_REMAP: begin
        if (lab_on) begin
          if (c.sep && grp_count >= NLAB) begin
            r.status = ST_FULL;
          end else begin
            if (c.sep) begin
              g = grp_count;
              grp_count++;
              grp_cost[g] = COST_INF;
            end else begin
              g = 32'(lbl_group[c.lab]);
            end
            lbl_valid[c.lab] = 1'b0;
            put_label(32'(c.new_lab), g, c.cost);
            r = ok_result(g);
          end
        end
      end
      ACT_REMOVE: begin
        if (lab_on) begin
          g = 32'(lbl_group[c.lab]);
          lbl_valid[c.lab] = 1'b0;
          r = ok_result(g);
        end
      end
      ACT_RECOMPUTE: begin
        if (grp_open) begin
          n_walks++;
          grp_cost[c.dest_group] = COST_INF;
          for (i = 0; i < NLAB; i++) begin
            if (lbl_valid[i] && lbl_group[i] == c.dest_group &&
                lbl_cost[i] < grp_cost[c.dest_group]) begin
              grp_cost[c.dest_group] = lbl_cost[i];
            end
          end
          r = ok_result(32'(c.dest_group));
        end
      end
      ACT_QUERY: begin
        if (lab_on) begin
          r = ok_result(32'(lbl_group[c.lab]));
        end
      end
      default: begin
      end
    endcase
    if (r.status == ST_FULL) begin
      n_full++;
    end
    if (r.status == ST_ABSENT) begin
      n_absent++;
    end
    results_due.push_front(r);
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return LABEL_W'($urandom_range(0, NLAB - 1));
    end
    if (r < 11) begin
      return r[0] ? LABEL_W'(NLAB - 1) : '0;
    end
    return LABEL_W'($urandom_range(0, 39));
  endfunction

  function automatic logic [LABEL_W-1:0] pick_present_label();
    logic [LABEL_W-1:0] l;
    int k;
    l = pick_label();
    for (k = 0; k < 6 && !lbl_valid[l]; k++) begin
      l = pick_label();
    end
    return l;
  endfunction

  function automatic logic [LABEL_W-1:0] pick_group();
    int unsigned r;
    logic [LABEL_W-1:0] l;
    r = $urandom_range(0, 99);
    if (grp_count == 0 || r < 6) begin
      return LABEL_W'($urandom_range(0, NLAB - 1));
    end
    if (r < 10) begin
      return LABEL_W'(grp_count);
    end
    if (r < 55) begin
      l = pick_present_label();
      if (lbl_valid[l]) begin
        return lbl_group[l];
      end
    end
    return LABEL_W'($urandom_range(0, grp_count - 1));
  endfunction

  function automatic logic [COST_PORT_W-1:0] pick_cost();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return '0;
    end
    if (r < 10) begin
      return COST_TOP;
    end
    if (r < 55) begin
      return COST_PORT_W'($urandom_range(0, 300));
    end
    return COST_PORT_W'($urandom_range(0, COST_TOP));
  endfunction

  function automatic lg_cmd_t random_cmd();
    lg_cmd_t c;
    int unsigned r;
    c.lab = pick_label();
    c.new_lab = pick_label();
    c.dest_group = pick_group();
    c.src_group = pick_group();
    c.cost = pick_cost();
    c.sep = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 10) begin
      c.action = ACT_NEW_GROUP;
    end else if (r < 35) begin
      c.action = ACT_ADD_LABEL;
    end else if (r < 45) begin
      c.action = ACT_MOVE_GROUP;
    end else if (r < 60) begin
      c.action = ACT_REMAP;
      c.lab = pick_present_label();
    end else if (r < 70) begin
      c.action = ACT_REMOVE;
      c.lab = pick_present_label();
    end else if (r < 78) begin
      c.action = ACT_RECOMPUTE;
    end else if (r < 98) begin
      c.action = ACT_QUERY;
      c.lab = pick_present_label();
    end else begin
      c.action = ACT_UNDEFINED;
    end
    return c;
  endfunction

  function automatic lg_cmd_t directed_cmd(input logic [ACTION_W-1:0] a,
                                           input int unsigned lab, input int unsigned nlab,
                                           input int unsigned grp, input int unsigned src,
                                           input int unsigned cost, input bit sep);
    lg_cmd_t c;
    c.action = a;
    c.lab = LABEL_W'(lab);
    c.new_lab = LABEL_W'(nlab);
    c.dest_group = LABEL_W'(grp);
    c.src_group = LABEL_W'(src);
    c.cost = COST_PORT_W'(cost);
    c.sep = sep;
    return c;
  endfunction

  task automatic push_cmd(input lg_cmd_t c);
    while (pending_cmds.size() >= 2) begin
      @(negedge clk);
    end
    pending_cmds.push_front(c);
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || start || results_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_group_result(cmd_on_port);
        n_beats++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cmd_on_port = pending_cmds.pop_back();
          in_action <= cmd_on_port.action;
          in_label <= cmd_on_port.lab;
          in_new_label <= cmd_on_port.new_lab;
          in_dest_group <= cmd_on_port.dest_group;
          in_source_group <= cmd_on_port.src_group;
          in_label_cost <= cmd_on_port.cost;
          in_separate_mode <= cmd_on_port.sep;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("unexpected result: group %0d cost %0d status %0d",
                   out_result_group, out_group_cost, out_status);
        end
      end else begin
        due_head = results_due.pop_back();
        n_checked++;
        if (out_result_group !== due_head.grp || out_group_cost !== due_head.cost ||
            out_status !== due_head.status) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("result %0d mismatch: group %0d/%0d cost %0d/%0d status %0d/%0d (exp/got)",
                     n_checked, due_head.grp, out_result_group, due_head.cost,
                     out_group_cost, due_head.status, out_status);
          end
        end
      end
    end
  end

  initial begin
    lg_cmd_t c;
    int ph;
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    push_cmd(directed_cmd(ACT_QUERY, 0, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_ADD_LABEL, 0, 0, 0, 0, 10, 0));
    push_cmd(directed_cmd(ACT_RECOMPUTE, 0, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_MOVE_GROUP, 0, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_NEW_GROUP, 0, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_NEW_GROUP, 0, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_ADD_LABEL, 0, 0, 0, 0, COST_TOP, 0));
    push_cmd(directed_cmd(ACT_ADD_LABEL, NLAB - 1, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_ADD_LABEL, 5, 0, 1, 0, 100, 0));
    push_cmd(directed_cmd(ACT_ADD_LABEL, NLAB - 1, 0, 1, 0, 7, 0));
    push_cmd(directed_cmd(ACT_QUERY, NLAB - 1, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_RECOMPUTE, 0, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_MOVE_GROUP, 0, 0, 0, 1, 0, 0));
    push_cmd(directed_cmd(ACT_MOVE_GROUP, 0, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_REMAP, 5, 5, 0, 0, 3, 0));
    push_cmd(directed_cmd(ACT_REMAP, 5, 9, 0, 0, 50, 1));
    push_cmd(directed_cmd(ACT_REMAP, 0, NLAB - 1, 0, 0, 20, 0));
    push_cmd(directed_cmd(ACT_REMOVE, 9, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_REMOVE, 9, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_RECOMPUTE, 0, 0, 2, 0, 0, 0));
    push_cmd(directed_cmd(ACT_UNDEFINED, NLAB - 1, NLAB - 1, NLAB - 1, NLAB - 1, COST_TOP, 1));
    push_cmd(directed_cmd(ACT_ADD_LABEL, 3, 0, NLAB - 1, 0, 1, 0));
    push_cmd(directed_cmd(ACT_MOVE_GROUP, 0, 0, 0, NLAB - 1, 0, 0));
    push_cmd(directed_cmd(ACT_REMAP, 700, 701, 0, 0, 1, 0));
    push_cmd(directed_cmd(ACT_QUERY, NLAB - 1, 0, 0, 0, 0, 0));
    drain();

    for (ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 84 : (ph == 3) ? 38 : 0;
      for (n = 0; n < 75; n++) begin
        if ($urandom_range(0, 99) == 0) begin
          drain();
        end
        push_cmd(random_cmd());
      end
      drain();
    end

    // Open groups until the table is full; the last few beats see it full.
    idle_pct = 0;
    while (grp_count < NLAB) begin
      c = random_cmd();
      c.action = ACT_NEW_GROUP;
      push_cmd(c);
    end
    drain();
    push_cmd(directed_cmd(ACT_NEW_GROUP, 0, 0, 0, 0, 0, 0));
    push_cmd(directed_cmd(ACT_ADD_LABEL, 7, 0, NLAB - 1, 0, 40, 0));
    push_cmd(directed_cmd(ACT_REMAP, 7, 8, 0, 0, 30, 1));
    drain();

    idle_pct = 38;
    for (n = 0; n < 100; n++) begin
      push_cmd(random_cmd());
    end
    drain();

    repeat (END_HOLD) @(posedge clk);
    if (results_due.size() != 0) begin
      n_errors++;
      $display("%0d expected results never arrived", results_due.size());
    end
    $display("Sent %0d beats and checked %0d results, %0d of them full label-table walks.",
             n_beats, n_checked, n_walks);
    $display("Saw %0d table-full and %0d not-present answers; %0d mismatches.",
             n_full, n_absent, n_errors);
    if (n_errors == 0) begin
      $display("label_group_min_cost_table_top_test: PASS");
    end else begin
      $display("label_group_min_cost_table_top_test: FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Timed out with %0d results still expected.", results_due.size());
    $display("label_group_min_cost_table_top_test: FAIL");
    $finish;
  end

endmodule
